>>> hw/rtl/mfrb_pkg.sv
package mfrb_pkg;

	localparam int NumChannels = 4;
	localparam int FifoDepth   = 8;

	localparam logic [7:0] AddrEnable    = 8'h20;
	localparam logic [7:0] AddrPending   = 8'h24;
	localparam logic [7:0] AddrCountBase = 8'h60;
	localparam logic [7:0] AddrFifoBase  = 8'h70;

	localparam logic [31:0] CountMask = 32'h0000_000f;

	typedef enum logic {
		CMD_READ  = 1'b0,
		CMD_WRITE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_UNMAPPED = 2'd3
	} status_t;

	typedef struct packed {
		logic        cmd;
		logic [7:0]  address;
		logic [31:0] write_data;
	} req_t;

	typedef struct packed {
		logic [31:0] read_data;
		status_t     access_status;
		logic        irq;
	} rsp_t;

endpackage

>>> hw/rtl/mailbox_fifo_register_block.sv
// channel  | signals                        | beat contents
// ---------+--------------------------------+-----------------------------------
// request  | req_valid, req_stall, req      | cmd, address, write_data
// response | rsp_valid, rsp_stall, rsp      | read_data, access_status, irq
//
// one access per cycle while the response side does not stall; a response is
// registered first in the memory-read stage, where the message memory is
// read, and then in the output register
// reset clears pointers, fill counts, enable and pending at once; the message
// memory is not cleared, a pop only ever reaches words that were pushed
// a stalled response holds the memory-read stage, which then stalls requests
module mailbox_fifo_register_block #(
	parameter int NUM_CHANNELS = mfrb_pkg::NumChannels,
	parameter int FIFO_DEPTH   = mfrb_pkg::FifoDepth
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  mfrb_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output mfrb_pkg::rsp_t  rsp
);

	localparam int CH_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int CNT_W     = $clog2(FIFO_DEPTH + 1);
	localparam int PTR_W     = $clog2(FIFO_DEPTH);
	localparam int SUM_W     = CNT_W + 1;
	localparam int MEM_DEPTH = NUM_CHANNELS * FIFO_DEPTH;
	localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam logic [5:0] NCH6 = 6'(NUM_CHANNELS);

	function automatic logic [31:0] spread_bits(input logic [NUM_CHANNELS-1:0] bits);
		logic [31:0] v;
		v = '0;
		for (int p = 0; p < NUM_CHANNELS; p++) begin
			v[2*p] = bits[p];
		end
		return v;
	endfunction

	function automatic logic [NUM_CHANNELS-1:0] gather_bits(input logic [31:0] word);
		logic [NUM_CHANNELS-1:0] v;
		for (int p = 0; p < NUM_CHANNELS; p++) begin
			v[p] = word[2*p];
		end
		return v;
	endfunction

	// state
	logic [CNT_W-1:0]        fill_q [NUM_CHANNELS];
	logic [PTR_W-1:0]        rd_ptr_q [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] en_q;
	logic [NUM_CHANNELS-1:0] pend_q;
	logic [31:0]             mem [MEM_DEPTH];

	// memory-read stage
	logic                s1_valid_q;
	logic                pop_s1;
	mfrb_pkg::status_t   status_s1;
	logic [31:0]         rdata_s1;
	logic                irq_s1;
	logic [31:0]         mem_rd_s1;

	// output register
	logic            rsp_valid_q;
	mfrb_pkg::rsp_t  rsp_q;

	logic req_acc;
	logic s1_adv;

	// decode
	logic                    is_wr;
	logic                    aligned;
	logic [7:0]              fifo_off;
	logic [7:0]              cnt_off;
	logic                    in_fifo_win;
	logic                    in_cnt_win;
	logic                    fifo_hit;
	logic                    cnt_hit;
	logic [CH_W-1:0]         ch;
	logic [CNT_W-1:0]        cnt;
	logic [PTR_W-1:0]        rp;
	logic [SUM_W-1:0]        pos_sum;
	logic [PTR_W-1:0]        wr_pos;
	logic [PTR_W-1:0]        rp_next;
	logic                    full;
	logic                    empty;
	logic                    do_push;
	logic                    do_pop;
	logic [MEM_AW-1:0]       ch_base;
	logic [MEM_AW-1:0]       wr_addr;
	logic [MEM_AW-1:0]       rd_addr;
	logic [NUM_CHANNELS-1:0] en_nx;
	logic [NUM_CHANNELS-1:0] pend_nx;
	mfrb_pkg::status_t       status_nx;
	logic [31:0]             rdata_nx;

	assign s1_adv    = s1_valid_q && (!rsp_valid_q || !rsp_stall);
	assign req_stall = s1_valid_q && !s1_adv;
	assign req_acc   = req_valid && !req_stall;

	always_comb begin
		is_wr       = (req.cmd == mfrb_pkg::CMD_WRITE);
		aligned     = (req.address[1:0] == 2'b00);
		fifo_off    = req.address - mfrb_pkg::AddrFifoBase;
		cnt_off     = req.address - mfrb_pkg::AddrCountBase;
		// the fifo window wins wherever the two windows would overlap
		in_fifo_win = aligned && (req.address >= mfrb_pkg::AddrFifoBase);
		in_cnt_win  = aligned && !in_fifo_win && (req.address >= mfrb_pkg::AddrCountBase);
		fifo_hit    = in_fifo_win && (fifo_off[7:2] < NCH6);
		cnt_hit     = in_cnt_win && (cnt_off[7:2] < NCH6);
		ch          = in_fifo_win ? fifo_off[CH_W+1:2] : cnt_off[CH_W+1:2];

		cnt     = fill_q[ch];
		rp      = rd_ptr_q[ch];
		pos_sum = SUM_W'(rp) + SUM_W'(cnt);
		wr_pos  = (pos_sum >= SUM_W'(FIFO_DEPTH)) ? PTR_W'(pos_sum - SUM_W'(FIFO_DEPTH))
		                                          : PTR_W'(pos_sum);
		rp_next = (rp == PTR_W'(FIFO_DEPTH - 1)) ? '0 : PTR_W'(rp + 1'b1);
		full    = (cnt == CNT_W'(FIFO_DEPTH));
		empty   = (cnt == '0);
		do_push = fifo_hit && is_wr && !full;
		do_pop  = fifo_hit && !is_wr && !empty;
		ch_base = MEM_AW'(ch) * MEM_AW'(FIFO_DEPTH);
		wr_addr = ch_base + MEM_AW'(wr_pos);
		rd_addr = ch_base + MEM_AW'(rp);

		en_nx     = en_q;
		pend_nx   = pend_q;
		status_nx = mfrb_pkg::ST_UNMAPPED;
		rdata_nx  = '0;
		if (req.address == mfrb_pkg::AddrEnable) begin
			status_nx = mfrb_pkg::ST_OK;
			if (is_wr) begin
				en_nx = gather_bits(req.write_data);
			end else begin
				rdata_nx = spread_bits(en_q);
			end
		end else if (req.address == mfrb_pkg::AddrPending) begin
			status_nx = mfrb_pkg::ST_OK;
			if (is_wr) begin
				pend_nx = pend_q & ~gather_bits(req.write_data);
			end else begin
				rdata_nx = spread_bits(pend_q);
			end
		end else if (fifo_hit) begin
			if (is_wr) begin
				status_nx = full ? mfrb_pkg::ST_FULL : mfrb_pkg::ST_OK;
				if (!full) begin
					pend_nx = pend_q | (NUM_CHANNELS'(1) << ch);
				end
			end else begin
				status_nx = empty ? mfrb_pkg::ST_EMPTY : mfrb_pkg::ST_OK;
			end
		end else if (cnt_hit) begin
			status_nx = mfrb_pkg::ST_OK;
			if (!is_wr) begin
				rdata_nx = 32'(cnt) & mfrb_pkg::CountMask;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				fill_q[i]   <= '0;
				rd_ptr_q[i] <= '0;
			end
			en_q   <= '0;
			pend_q <= '0;
		end else if (req_acc) begin
			en_q   <= en_nx;
			pend_q <= pend_nx;
			if (do_push) begin
				fill_q[ch] <= CNT_W'(cnt + 1'b1);
			end else if (do_pop) begin
				fill_q[ch]   <= CNT_W'(cnt - 1'b1);
				rd_ptr_q[ch] <= rp_next;
			end
		end
	end

	// message memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (req_acc && do_push) begin
			mem[wr_addr] <= req.write_data;
		end
		if (req_acc && do_pop) begin
			mem_rd_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (req_acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			pop_s1    <= do_pop;
			status_s1 <= status_nx;
			rdata_s1  <= rdata_nx;
			irq_s1    <= |(en_nx & pend_nx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_adv) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			rsp_q.read_data     <= pop_s1 ? mem_rd_s1 : rdata_s1;
			rsp_q.access_status <= status_s1;
			rsp_q.irq           <= irq_s1;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	// a held memory-read stage must block new requests
	a_stall_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_adv) |-> req_stall)
		else $error("request taken while read stage is blocked");

	// a pop that read the memory always reports ok
	a_pop_status_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && pop_s1) |-> (status_s1 == mfrb_pkg::ST_OK))
		else $error("memory pop with non-ok status");

	// a push to a full fifo leaves pending alone and reports full
	a_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && fifo_hit && is_wr && full)
		|=> (status_s1 == mfrb_pkg::ST_FULL) && $stable(pend_q))
		else $error("push to full fifo not dropped");

	// an accepted beat occupies the read stage on the next cycle
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> s1_valid_q)
		else $error("accepted beat lost before read stage");
`endif

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int QuietLimit = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	mfrb_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	mfrb_pkg::rsp_t rsp;

	// no idling on either side while set
	bit steady = 1'b0;
	int mismatches = 0;

	// mirror of the mailbox state
	logic [31:0] chan_words[mfrb_pkg::NumChannels][mfrb_pkg::FifoDepth];
	int unsigned chan_head[mfrb_pkg::NumChannels] = '{default: 0};
	int unsigned chan_fill[mfrb_pkg::NumChannels] = '{default: 0};
	logic [mfrb_pkg::NumChannels-1:0] irq_enabled = '0;
	logic [mfrb_pkg::NumChannels-1:0] irq_pending = '0;

	mfrb_pkg::rsp_t awaited_replies[$];

	mailbox_fifo_register_block dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// channel bit p sits at bus bit 2p
	function automatic logic [31:0] spread_chan(
			input logic [mfrb_pkg::NumChannels-1:0] bits);
		logic [31:0] w;
		w = '0;
		for (int p = 0; p < mfrb_pkg::NumChannels; p++)
			w[2*p] = bits[p];
		return w;
	endfunction

	function automatic logic [mfrb_pkg::NumChannels-1:0] gather_chan(input logic [31:0] w);
		logic [mfrb_pkg::NumChannels-1:0] bits;
		for (int p = 0; p < mfrb_pkg::NumChannels; p++)
			bits[p] = w[2*p];
		return bits;
	endfunction

	function automatic mfrb_pkg::rsp_t mailbox_predict(input mfrb_pkg::req_t a);
		mfrb_pkg::rsp_t r;
		int ch;
		int unsigned slot;
		r.read_data = '0;
		r.access_status = mfrb_pkg::ST_UNMAPPED;
		if (a.address == mfrb_pkg::AddrEnable) begin
			r.access_status = mfrb_pkg::ST_OK;
			if (a.cmd == mfrb_pkg::CMD_WRITE)
				irq_enabled = gather_chan(a.write_data);
			else
				r.read_data = spread_chan(irq_enabled);
		end else if (a.address == mfrb_pkg::AddrPending) begin
			r.access_status = mfrb_pkg::ST_OK;
			if (a.cmd == mfrb_pkg::CMD_WRITE)
				irq_pending = irq_pending & ~gather_chan(a.write_data);
			else
				r.read_data = spread_chan(irq_pending);
		end else if (a.address[1:0] == 2'b00 && a.address >= mfrb_pkg::AddrFifoBase) begin
			ch = (int'(a.address) - int'(mfrb_pkg::AddrFifoBase)) / 4;
			if (ch < mfrb_pkg::NumChannels) begin
				if (a.cmd == mfrb_pkg::CMD_WRITE) begin
					if (chan_fill[ch] >= mfrb_pkg::FifoDepth) begin
						r.access_status = mfrb_pkg::ST_FULL;
					end else begin
						slot = (chan_head[ch] + chan_fill[ch]) % mfrb_pkg::FifoDepth;
						chan_words[ch][slot] = a.write_data;
						chan_fill[ch]++;
						irq_pending[ch] = 1'b1;
						r.access_status = mfrb_pkg::ST_OK;
					end
				end else if (chan_fill[ch] == 0) begin
					r.access_status = mfrb_pkg::ST_EMPTY;
				end else begin
					r.read_data = chan_words[ch][chan_head[ch]];
					chan_head[ch] = (chan_head[ch] + 1) % mfrb_pkg::FifoDepth;
					chan_fill[ch]--;
					r.access_status = mfrb_pkg::ST_OK;
				end
			end
		end else if (a.address[1:0] == 2'b00 && a.address >= mfrb_pkg::AddrCountBase) begin
			ch = (int'(a.address) - int'(mfrb_pkg::AddrCountBase)) / 4;
			if (ch < mfrb_pkg::NumChannels) begin
				r.access_status = mfrb_pkg::ST_OK;
				if (a.cmd == mfrb_pkg::CMD_READ)
					r.read_data = chan_fill[ch] & mfrb_pkg::CountMask;
			end
		end
		if (a.cmd == mfrb_pkg::CMD_WRITE)
			r.read_data = '0;
		r.irq = |(irq_enabled & irq_pending);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// every accepted request beat is predicted at once
	always @(posedge clk) begin
		if (arst_n && req_valid && !req_stall)
			awaited_replies.push_back(mailbox_predict(req));
	end

	always @(posedge clk) begin : reply_check
		mfrb_pkg::rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (awaited_replies.size() == 0) begin
				report_mismatch("reply with none awaited", rsp.read_data, '0);
			end else begin
				want = awaited_replies.pop_front();
				if (rsp.read_data !== want.read_data)
					report_mismatch("read_data", rsp.read_data, want.read_data);
				if (rsp.access_status !== want.access_status)
					report_mismatch("access_status", 32'(rsp.access_status),
						32'(want.access_status));
				if (rsp.irq !== want.irq)
					report_mismatch("irq", 32'(rsp.irq), 32'(want.irq));
			end
		end
	end

	always @(posedge clk)
		rsp_stall <= !steady && ($urandom_range(0, 99) < 6);

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QuietLimit) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("testbench: done, errors");
		$finish;
	end

	function automatic mfrb_pkg::req_t bus_access(input mfrb_pkg::cmd_t c,
			input logic [7:0] a, input logic [31:0] d);
		mfrb_pkg::req_t r;
		r.cmd = c;
		r.address = a;
		r.write_data = d;
		return r;
	endfunction

	// returns at the edge where the beat is taken, valid still high
	task automatic send_access(input mfrb_pkg::req_t item);
		if (!steady && $urandom_range(0, 99) < 6) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic wait_all_replies();
		req_valid <= 1'b0;
		@(posedge clk);
		while (awaited_replies.size() != 0)
			@(posedge clk);
	endtask

	// mostly push/pop traffic, push share steers the fill level
	function automatic mfrb_pkg::req_t random_access(input int push_pct);
		int pick;
		int ch;
		logic [7:0] fifo_addr;
		pick = $urandom_range(0, 99);
		ch = $urandom_range(0, mfrb_pkg::NumChannels - 1);
		fifo_addr = mfrb_pkg::AddrFifoBase + 8'(4 * ch);
		if (pick < push_pct * 70 / 100)
			return bus_access(mfrb_pkg::CMD_WRITE, fifo_addr, $urandom);
		if (pick < 70)
			return bus_access(mfrb_pkg::CMD_READ, fifo_addr, $urandom);
		if (pick < 78)
			return bus_access(mfrb_pkg::cmd_t'($urandom_range(0, 1)),
				mfrb_pkg::AddrCountBase + 8'(4 * ch), $urandom);
		if (pick < 86)
			return bus_access(mfrb_pkg::cmd_t'($urandom_range(0, 1)),
				$urandom_range(0, 1) ? mfrb_pkg::AddrEnable : mfrb_pkg::AddrPending,
				$urandom);
		return bus_access(mfrb_pkg::cmd_t'($urandom_range(0, 1)),
			8'($urandom_range(0, 255)), $urandom);
	endfunction

	task automatic test_reset_and_edges();
		send_access(bus_access(mfrb_pkg::CMD_READ, mfrb_pkg::AddrEnable, '1));
		send_access(bus_access(mfrb_pkg::CMD_READ, mfrb_pkg::AddrPending, '0));
		send_access(bus_access(mfrb_pkg::CMD_READ,
			mfrb_pkg::AddrCountBase + 8'(4 * (mfrb_pkg::NumChannels - 1)), '0));
		// pop from an empty fifo
		send_access(bus_access(mfrb_pkg::CMD_READ, mfrb_pkg::AddrFifoBase + 8'd4, '0));
		send_access(bus_access(mfrb_pkg::CMD_WRITE, mfrb_pkg::AddrEnable, 32'hffff_ffff));
		send_access(bus_access(mfrb_pkg::CMD_READ, mfrb_pkg::AddrEnable, '0));
		for (int i = 0; i < mfrb_pkg::FifoDepth; i++)
			send_access(bus_access(mfrb_pkg::CMD_WRITE, mfrb_pkg::AddrFifoBase,
				i == 0 ? 32'hffff_ffff : (i == 1 ? 32'h0 : $urandom)));
		// push into a full fifo is dropped
		send_access(bus_access(mfrb_pkg::CMD_WRITE, mfrb_pkg::AddrFifoBase, 32'h1234_5678));
		send_access(bus_access(mfrb_pkg::CMD_READ, mfrb_pkg::AddrCountBase, '0));
		send_access(bus_access(mfrb_pkg::CMD_WRITE, mfrb_pkg::AddrCountBase, 32'hffff_ffff));
		send_access(bus_access(mfrb_pkg::CMD_READ, mfrb_pkg::AddrFifoBase, '0));
		// odd bits of pending are not channel bits
		send_access(bus_access(mfrb_pkg::CMD_WRITE, mfrb_pkg::AddrPending, 32'haaaa_aaaa));
		send_access(bus_access(mfrb_pkg::CMD_WRITE, mfrb_pkg::AddrPending, 32'hffff_ffff));
		send_access(bus_access(mfrb_pkg::CMD_READ, mfrb_pkg::AddrPending, '0));
		send_access(bus_access(mfrb_pkg::CMD_READ, 8'h00, '0));
		send_access(bus_access(mfrb_pkg::CMD_WRITE, 8'hff, 32'hffff_ffff));
		send_access(bus_access(mfrb_pkg::CMD_READ, mfrb_pkg::AddrFifoBase + 8'd1, '0));
		send_access(bus_access(mfrb_pkg::CMD_READ,
			mfrb_pkg::AddrFifoBase + 8'(4 * mfrb_pkg::NumChannels), '0));
		send_access(bus_access(mfrb_pkg::CMD_WRITE, mfrb_pkg::AddrCountBase - 8'd4,
			32'h5555_5555));
	endtask

	task automatic test_random_traffic(input int count);
		int push_pct;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0)
				push_pct = $urandom_range(15, 85);
			send_access(random_access(push_pct));
		end
	endtask

	task automatic test_back_to_back(input int count);
		steady = 1'b1;
		for (int i = 0; i < count; i++)
			send_access(random_access(50));
		steady = 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_and_edges();
		wait_all_replies();
		test_random_traffic(1500);
		wait_all_replies();
		test_back_to_back(330);
		wait_all_replies();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
